// File: hdl/friction_cone_impulse_clamp_unit_defines.svh
// Assertion macros shared by the friction cone clamp RTL.
// No dependencies; included by the top level only.
`ifndef FRICTION_CONE_IMPULSE_CLAMP_UNIT_DEFINES_SVH
`define FRICTION_CONE_IMPULSE_CLAMP_UNIT_DEFINES_SVH

// Check a property while out of reset.
`define FCIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FCIC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/fcic_pkg.sv
// Shared constants, sideband types and step functions of the friction cone clamp.
// No dependencies; used by every module of the block.
package fcic_pkg;

    localparam int IMP_W     = 32;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 12;
    localparam int NORM_W    = IMP_W - 1;
    localparam int SQ_W      = 2 * IMP_W;
    localparam int REM_W     = IMP_W + 4;
    localparam int LPROD_W   = COEF_W + NORM_W;
    localparam int LSHR_W    = LPROD_W - COEF_FRAC;
    localparam int IN_W      = 3 * IMP_W + 2 * COEF_W;
    localparam int OUT_W     = ((NORM_W + 2 * IMP_W + 7) / 8) * 8;

    // Sideband that rides along the square root pipeline
    typedef struct packed {
        logic              sgn_a;
        logic              sgn_b;
        logic [IMP_W-1:0]  ma;
        logic [IMP_W-1:0]  mb;
        logic [NORM_W-1:0] normal;
        logic [IMP_W-1:0]  lim_s;
        logic [IMP_W-1:0]  lim_d;
    } t_sq_side;

    // Sideband that rides along the divider pipeline
    typedef struct packed {
        logic              scale;
        logic              sgn_a;
        logic              sgn_b;
        logic [IMP_W-1:0]  ma;
        logic [IMP_W-1:0]  mb;
        logic [NORM_W-1:0] normal;
    } t_dv_side;

    // Coefficient times normal, truncated and saturated to the impulse width
    function automatic logic [IMP_W-1:0] limit_of(input logic [COEF_W-1:0] coef,
                                                  input logic [NORM_W-1:0] normal);
        logic [LPROD_W-1:0] p;
        logic [LSHR_W-1:0]  s;
        p = LPROD_W'(coef) * LPROD_W'(normal);
        s = p[LPROD_W-1:COEF_FRAC];
        if (s > LSHR_W'({IMP_W{1'b1}})) begin
            return {IMP_W{1'b1}};
        end
        return s[IMP_W-1:0];
    endfunction

endpackage

// File: hdl/fcic_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on fcic_pkg.
module fcic_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [fcic_pkg::SQ_W-1:0]  i_x,
    input  fcic_pkg::t_sq_side      i_side,
    output logic                    o_vld,
    output logic [fcic_pkg::IMP_W-1:0] o_root,
    output fcic_pkg::t_sq_side      o_side
);
    import fcic_pkg::*;

    logic                   r_vld  [IMP_W];
    logic [REM_W-1:0]       r_rem  [IMP_W];
    logic [IMP_W-1:0]       r_root [IMP_W];
    logic [SQ_W-1:0]        r_x    [IMP_W];
    t_sq_side               r_side [IMP_W];

    genvar k;
    generate
        for (k = 0; k < IMP_W; k++) begin : g_stage
            logic             p_vld;
            logic [REM_W-1:0] p_rem;
            logic [IMP_W-1:0] p_root;
            logic [SQ_W-1:0]  p_x;
            t_sq_side         p_side;
            logic [REM_W-1:0] n_t;
            logic [REM_W-1:0] n_trial;

            if (k == 0) begin : g_first
                assign p_vld  = i_vld;
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_x    = i_x;
                assign p_side = i_side;
            end else begin : g_next
                assign p_vld  = r_vld[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_root = r_root[k-1];
                assign p_x    = r_x[k-1];
                assign p_side = r_side[k-1];
            end

            // Bring down two radicand bits and try the next root bit
            assign n_t     = {p_rem[REM_W-3:0], p_x[SQ_W-1 -: 2]};
            assign n_trial = {2'b00, p_root, 2'b01};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= p_vld;
                end
                if (i_en) begin
                    if (n_t >= n_trial) begin
                        r_rem[k]  <= n_t - n_trial;
                        r_root[k] <= {p_root[IMP_W-2:0], 1'b1};
                    end else begin
                        r_rem[k]  <= n_t;
                        r_root[k] <= {p_root[IMP_W-2:0], 1'b0};
                    end
                    r_x[k]    <= {p_x[SQ_W-3:0], 2'b00};
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[IMP_W-1];
    assign o_root = r_root[IMP_W-1];
    assign o_side = r_side[IMP_W-1];

endmodule

// File: hdl/fcic_div.sv
// Pipelined restoring divider for both tangents, one quotient bit per stage.
// Depends on fcic_pkg; the divisor is the tangential magnitude.
module fcic_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [fcic_pkg::SQ_W-1:0]  i_dd_a,
    input  logic [fcic_pkg::SQ_W-1:0]  i_dd_b,
    input  logic [fcic_pkg::IMP_W-1:0] i_dvs,
    input  fcic_pkg::t_dv_side         i_side,
    output logic                       o_vld,
    output logic [fcic_pkg::IMP_W-1:0] o_q_a,
    output logic [fcic_pkg::IMP_W-1:0] o_q_b,
    output fcic_pkg::t_dv_side         o_side
);
    import fcic_pkg::*;

    logic             r_vld  [IMP_W];
    logic [IMP_W-1:0] r_rem_a[IMP_W];
    logic [IMP_W-1:0] r_rem_b[IMP_W];
    logic [IMP_W-1:0] r_lo_a [IMP_W];
    logic [IMP_W-1:0] r_lo_b [IMP_W];
    logic [IMP_W-1:0] r_q_a  [IMP_W];
    logic [IMP_W-1:0] r_q_b  [IMP_W];
    logic [IMP_W-1:0] r_dvs  [IMP_W];
    t_dv_side         r_side [IMP_W];

    genvar k;
    generate
        for (k = 0; k < IMP_W; k++) begin : g_stage
            logic             p_vld;
            logic [IMP_W-1:0] p_rem_a, p_rem_b, p_lo_a, p_lo_b, p_q_a, p_q_b, p_dvs;
            t_dv_side         p_side;
            logic [IMP_W:0]   n_t_a, n_t_b, n_d_a, n_d_b;

            if (k == 0) begin : g_first
                assign p_vld   = i_vld;
                assign p_rem_a = i_dd_a[SQ_W-1:IMP_W];
                assign p_rem_b = i_dd_b[SQ_W-1:IMP_W];
                assign p_lo_a  = i_dd_a[IMP_W-1:0];
                assign p_lo_b  = i_dd_b[IMP_W-1:0];
                assign p_q_a   = '0;
                assign p_q_b   = '0;
                assign p_dvs   = i_dvs;
                assign p_side  = i_side;
            end else begin : g_next
                assign p_vld   = r_vld[k-1];
                assign p_rem_a = r_rem_a[k-1];
                assign p_rem_b = r_rem_b[k-1];
                assign p_lo_a  = r_lo_a[k-1];
                assign p_lo_b  = r_lo_b[k-1];
                assign p_q_a   = r_q_a[k-1];
                assign p_q_b   = r_q_b[k-1];
                assign p_dvs   = r_dvs[k-1];
                assign p_side  = r_side[k-1];
            end

            // Shift in the next dividend bit and subtract where it fits
            assign n_t_a = {p_rem_a, p_lo_a[IMP_W-1]};
            assign n_t_b = {p_rem_b, p_lo_b[IMP_W-1]};
            assign n_d_a = n_t_a - {1'b0, p_dvs};
            assign n_d_b = n_t_b - {1'b0, p_dvs};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= p_vld;
                end
                if (i_en) begin
                    if (n_t_a >= {1'b0, p_dvs}) begin
                        r_rem_a[k] <= n_d_a[IMP_W-1:0];
                        r_q_a[k]   <= {p_q_a[IMP_W-2:0], 1'b1};
                    end else begin
                        r_rem_a[k] <= n_t_a[IMP_W-1:0];
                        r_q_a[k]   <= {p_q_a[IMP_W-2:0], 1'b0};
                    end
                    if (n_t_b >= {1'b0, p_dvs}) begin
                        r_rem_b[k] <= n_d_b[IMP_W-1:0];
                        r_q_b[k]   <= {p_q_b[IMP_W-2:0], 1'b1};
                    end else begin
                        r_rem_b[k] <= n_t_b[IMP_W-1:0];
                        r_q_b[k]   <= {p_q_b[IMP_W-2:0], 1'b0};
                    end
                    r_lo_a[k] <= {p_lo_a[IMP_W-2:0], 1'b0};
                    r_lo_b[k] <= {p_lo_b[IMP_W-2:0], 1'b0};
                    r_dvs[k]  <= p_dvs;
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[IMP_W-1];
    assign o_q_a  = r_q_a[IMP_W-1];
    assign o_q_b  = r_q_b[IMP_W-1];
    assign o_side = r_side[IMP_W-1];

endmodule

// File: hdl/friction_cone_impulse_clamp_unit.sv
// Friction cone clamp top level: front stages, limit select, output stage.
// Depends on fcic_pkg, fcic_sqrt, fcic_div and the assertion macro header.
//
// Usage:
//   One contact enters per beat on s_axis; one clamped result leaves per beat
//   on m_axis. Input tdata holds tangent_in_a, tangent_in_b, normal_impulse,
//   static_coef and dynamic_coef from the lowest bit up. Output tdata holds
//   normal_out, tangent_out_a and tangent_out_b from the lowest bit up.
//   The pipeline has three front stages (magnitudes, squares and saturated limit
//   products, sum of squares), 32 square root stages (one root bit each),
//   limit select, scale products, 32 divider stages (one quotient bit each)
//   and the output register. Throughput is one contact per cycle while m_axis is not stalled.
//   All stages advance together; when the receiver stalls with a result
//   waiting, the whole pipeline holds and s_axis_tready drops, so nothing is
//   lost or repeated. Synchronous reset clears every valid bit; results in
//   flight are dropped.
module friction_cone_impulse_clamp_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tangent_in_a, tangent_in_b, normal_impulse, static_coef, dynamic_coef
    input  logic [fcic_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // normal_out, tangent_out_a, tangent_out_b, zero fill
    output logic [fcic_pkg::OUT_W-1:0]  m_axis_tdata
);
    import fcic_pkg::*;
    `include "friction_cone_impulse_clamp_unit_defines.svh"

    logic en;

    logic [IMP_W-1:0]  in_ta, in_tb, in_nr;
    logic [COEF_W-1:0] in_cs, in_cd;

    // Stage 1: magnitudes and clamped normal
    logic              r1_vld, r1_sa, r1_sb;
    logic [IMP_W-1:0]  r1_ma, r1_mb;
    logic [NORM_W-1:0] r1_nr;
    logic [COEF_W-1:0] r1_cs, r1_cd;

    // Stage 2: squares and limit products
    logic              r2_vld;
    logic [SQ_W-1:0]   r2_sqa, r2_sqb;
    logic [IMP_W-1:0]  r2_ls, r2_ld;
    logic              r2_sa, r2_sb;
    logic [IMP_W-1:0]  r2_ma, r2_mb;
    logic [NORM_W-1:0] r2_nr;

    // Stage 3: sum of squares
    logic              r3_vld;
    logic [SQ_W-1:0]   r3_sum;
    t_sq_side          r3_side;

    logic              sq_vld;
    logic [IMP_W-1:0]  sq_root;
    t_sq_side          sq_side;

    // Stage 4: limit select
    logic              r4_vld;
    logic [IMP_W-1:0]  r4_mag, r4_lim;
    t_dv_side          r4_side;
    logic [IMP_W-1:0]  n_lim;

    // Stage 5: scale products
    logic              r5_vld;
    logic [SQ_W-1:0]   r5_pa, r5_pb;
    logic [IMP_W-1:0]  r5_mag;
    t_dv_side          r5_side;

    logic              dv_vld;
    logic [IMP_W-1:0]  dv_qa, dv_qb;
    t_dv_side          dv_side;

    // Output register
    logic              r_out_vld;
    logic [NORM_W-1:0] r_out_nr;
    logic [IMP_W-1:0]  r_out_ta, r_out_tb;
    logic [IMP_W-1:0]  n_ta, n_tb;

    // Advance every stage unless a result waits on a stalled receiver
    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    assign in_ta = s_axis_tdata[IMP_W-1:0];
    assign in_tb = s_axis_tdata[2*IMP_W-1:IMP_W];
    assign in_nr = s_axis_tdata[3*IMP_W-1:2*IMP_W];
    assign in_cs = s_axis_tdata[3*IMP_W+COEF_W-1:3*IMP_W];
    assign in_cd = s_axis_tdata[3*IMP_W+2*COEF_W-1:3*IMP_W+COEF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
        if (en) begin
            r1_sa <= in_ta[IMP_W-1];
            r1_sb <= in_tb[IMP_W-1];
            r1_ma <= in_ta[IMP_W-1] ? (~in_ta + 1'b1) : in_ta;
            r1_mb <= in_tb[IMP_W-1] ? (~in_tb + 1'b1) : in_tb;
            r1_nr <= in_nr[IMP_W-1] ? '0 : in_nr[NORM_W-1:0];
            r1_cs <= in_cs;
            r1_cd <= in_cd;

            r2_sqa <= SQ_W'(r1_ma) * SQ_W'(r1_ma);
            r2_sqb <= SQ_W'(r1_mb) * SQ_W'(r1_mb);
            r2_ls  <= limit_of(r1_cs, r1_nr);
            r2_ld  <= limit_of(r1_cd, r1_nr);
            r2_sa  <= r1_sa;
            r2_sb  <= r1_sb;
            r2_ma  <= r1_ma;
            r2_mb  <= r1_mb;
            r2_nr  <= r1_nr;

            r3_sum         <= r2_sqa + r2_sqb;
            r3_side.sgn_a  <= r2_sa;
            r3_side.sgn_b  <= r2_sb;
            r3_side.ma     <= r2_ma;
            r3_side.mb     <= r2_mb;
            r3_side.normal <= r2_nr;
            r3_side.lim_s  <= r2_ls;
            r3_side.lim_d  <= r2_ld;
        end
    end

    fcic_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_x     (r3_sum),
        .i_side  (r3_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Pick the static limit when inside the cone, else the dynamic one
    assign n_lim = (sq_root <= sq_side.lim_s) ? sq_side.lim_s : sq_side.lim_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= sq_vld;
            r5_vld <= r4_vld;
        end
        if (en) begin
            r4_mag         <= sq_root;
            r4_lim         <= n_lim;
            r4_side.scale  <= (sq_root > n_lim) && (sq_root != '0);
            r4_side.sgn_a  <= sq_side.sgn_a;
            r4_side.sgn_b  <= sq_side.sgn_b;
            r4_side.ma     <= sq_side.ma;
            r4_side.mb     <= sq_side.mb;
            r4_side.normal <= sq_side.normal;

            r5_pa   <= SQ_W'(r4_side.ma) * SQ_W'(r4_lim);
            r5_pb   <= SQ_W'(r4_side.mb) * SQ_W'(r4_lim);
            r5_mag  <= r4_mag;
            r5_side <= r4_side;
        end
    end

    fcic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r5_vld),
        .i_dd_a  (r5_pa),
        .i_dd_b  (r5_pb),
        .i_dvs   (r5_mag),
        .i_side  (r5_side),
        .o_vld   (dv_vld),
        .o_q_a   (dv_qa),
        .o_q_b   (dv_qb),
        .o_side  (dv_side)
    );

    // Restore signs; pass the tangents unchanged when no scaling applies
    always_comb begin
        n_ta = dv_side.scale ? dv_qa : dv_side.ma;
        n_tb = dv_side.scale ? dv_qb : dv_side.mb;
        if (dv_side.sgn_a) begin
            n_ta = ~n_ta + 1'b1;
        end
        if (dv_side.sgn_b) begin
            n_tb = ~n_tb + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
        if (en) begin
            r_out_nr <= dv_side.normal;
            r_out_ta <= n_ta;
            r_out_tb <= n_tb;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_out_tb, r_out_ta, r_out_nr});

    `FCIC_ASSERT(a_ready_tracks_output, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready does not follow output stall")
    `FCIC_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    `FCIC_ASSERT(a_scale_needs_mag, r4_vld && r4_side.scale |-> r4_mag > r4_lim, "scaling without magnitude above limit")

endmodule
